// ----- src/spf_pkg.sv -----
// Package for the simplex projection block: payload types, constants, FSM states.
// No dependencies.
package spf_pkg;

    localparam int MAX_TERMS = 64;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;

    localparam logic [0:0] REG_TOTAL = 1'b0;
    localparam logic [0:0] REG_FLOOR = 1'b1;

    typedef struct packed {
        logic signed [31:0] value_in;
        logic               last_in;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] value_out;
        logic [5:0]         index_out;
        logic               last_out;
        logic               truncated;
        logic               bad_total;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CHECK,
        ST_OUTER,
        ST_INNER,
        ST_JUDGE,
        ST_DIV,
        ST_EMIT_RD,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clr_outer;
        logic rd_j;
        logic clr_inner;
        logic acc_inner;
        logic judge;
        logic div_start;
        logic div_step;
        logic clr_emit;
        logic rd_emit;
        logic emit;
        logic done;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic bad;
        logic j_last;
        logic i_last;
        logic div_last;
        logic e_last;
    } status_t;

endpackage

// ----- src/simplex_projection_with_floor.sv -----
// Top level of the simplex projection block: controller plus datapath.
// Depends on spf_pkg, spf_ctrl, spf_dp.
//
// Elements are loaded one per cycle while busy is low; the beat with last_in
// set closes the vector. The block then runs a pairwise threshold search over
// the single store read port and a serial divider, both skipped when the
// reduced total is not positive, and emits each result after a store read.
// Results carry a one-cycle strobe and cannot be held off by the receiver.
module simplex_projection_with_floor (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  spf_pkg::in_beat_t    in_beat,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [30:0]          cfg_data,
    output logic                 strobe,
    output spf_pkg::out_beat_t   out_beat
);

    spf_pkg::cmd_t    cmd;
    spf_pkg::status_t status;
    logic             close;
    logic             load;

    assign load = start && !busy;

    spf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .close  (close),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    spf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .in_beat   (in_beat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .close     (close),
        .strobe    (strobe),
        .out_beat  (out_beat)
    );

endmodule

// ----- src/spf_ctrl.sv -----
// Controller FSM for the simplex projection block.
// Depends on spf_pkg.
module spf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              close,
    input  spf_pkg::status_t  status,
    output spf_pkg::cmd_t     cmd,
    output logic              busy
);

    spf_pkg::state_t state_reg, state_next;

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= spf_pkg::ST_LOAD;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spf_pkg::ST_LOAD:    if (close) state_next = spf_pkg::ST_CHECK;
            spf_pkg::ST_CHECK:   state_next = status.bad ? spf_pkg::ST_EMIT_RD
                                                         : spf_pkg::ST_OUTER;
            spf_pkg::ST_OUTER:   state_next = spf_pkg::ST_INNER;
            spf_pkg::ST_INNER:   if (status.i_last) state_next = spf_pkg::ST_JUDGE;
            spf_pkg::ST_JUDGE:   state_next = status.j_last ? spf_pkg::ST_DIV
                                                            : spf_pkg::ST_OUTER;
            spf_pkg::ST_DIV:     if (status.div_last) state_next = spf_pkg::ST_EMIT_RD;
            spf_pkg::ST_EMIT_RD: state_next = spf_pkg::ST_EMIT;
            spf_pkg::ST_EMIT:    state_next = status.e_last ? spf_pkg::ST_LOAD
                                                            : spf_pkg::ST_EMIT_RD;
            default:             state_next = spf_pkg::ST_LOAD;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        busy = 1'b1;
        case (state_reg)
            spf_pkg::ST_LOAD:
            begin
                busy = 1'b0;
                cmd.clr_outer = 1'b1;
                cmd.clr_emit = 1'b1;
            end
            spf_pkg::ST_CHECK:   cmd.clr_outer = 1'b1;
            spf_pkg::ST_OUTER:
            begin
                cmd.rd_j = 1'b1;
                cmd.clr_inner = 1'b1;
            end
            spf_pkg::ST_INNER:   cmd.acc_inner = 1'b1;
            spf_pkg::ST_JUDGE:
            begin
                cmd.judge = 1'b1;
                cmd.div_start = status.j_last;
            end
            spf_pkg::ST_DIV:     cmd.div_step = 1'b1;
            spf_pkg::ST_EMIT_RD: cmd.rd_emit = 1'b1;
            spf_pkg::ST_EMIT:
            begin
                cmd.emit = 1'b1;
                cmd.done = status.e_last;
            end
            default:             cmd = '0;
        endcase
    end

endmodule

// ----- src/spf_dp.sv -----
// Datapath for the simplex projection block: element store, pairwise
// threshold search, serial divider and emit stage. Depends on spf_pkg.
module spf_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  spf_pkg::in_beat_t    in_beat,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [30:0]          cfg_data,
    input  spf_pkg::cmd_t        cmd,
    output spf_pkg::status_t     status,
    output logic                 close,
    output logic                 strobe,
    output spf_pkg::out_beat_t   out_beat
);

    localparam int IW = spf_pkg::IDX_W;
    localparam int CW = spf_pkg::CNT_W;

    logic signed [31:0] mem [spf_pkg::MAX_TERMS];

    logic [30:0]        total_reg;
    logic [15:0]        floor_reg;
    logic [CW-1:0]      count_reg;
    logic               ovf_reg;
    logic               bad_reg;
    logic signed [40:0] reduced_reg;
    logic [IW-1:0]      j_reg;
    logic [IW-1:0]      i_reg;
    logic signed [31:0] sj_reg;
    logic               si_valid_reg;
    logic signed [40:0] s_reg;
    logic [CW-1:0]      c_reg;
    logic signed [40:0] ksum_reg;
    logic [CW-1:0]      kcnt_reg;
    logic [41:0]        rem_reg;
    logic [41:0]        quo_reg;
    logic               neg_reg;
    logic [5:0]         dstep_reg;
    logic signed [31:0] theta_reg;
    logic [IW-1:0]      e_reg;
    logic signed [31:0] rd_reg;
    logic               strobe_reg;
    spf_pkg::out_beat_t out_reg;

    logic signed [32:0] shift_wide;
    logic signed [31:0] shifted;
    logic [IW-1:0]      last_idx;

    assign last_idx = IW'(count_reg - CW'(1));
    assign shift_wide = 33'(in_beat.value_in) - 33'(signed'({1'b0, floor_reg}));
    assign shifted = (shift_wide < -33'sd2147483648) ? 32'sh8000_0000 : shift_wide[31:0];

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= 31'd65536;
            floor_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == spf_pkg::REG_TOTAL)
                total_reg <= cfg_data;
            else
                floor_reg <= cfg_data[15:0];
        end
    end

    // store element
    always_ff @(posedge clk)
    begin
        if (load && count_reg < CW'(spf_pkg::MAX_TERMS))
            mem[count_reg[IW-1:0]] <= shifted;
    end

    // single read port
    logic [IW-1:0] rd_addr;
    always_comb
    begin
        rd_addr = i_reg;
        if (cmd.rd_j)
            rd_addr = j_reg;
        else if (cmd.rd_emit)
            rd_addr = e_reg;
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= mem[rd_addr];
    end

    assign close = load && in_beat.last_in;

    // element count, overflow flag, reduced total
    logic signed [40:0] fl_n;
    logic signed [40:0] reduced_now;
    assign fl_n = 41'(signed'({1'b0, floor_reg})) * 41'(signed'({1'b0, count_reg}));
    assign reduced_now = 41'(signed'({1'b0, total_reg})) - fl_n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg <= 1'b0;
            bad_reg <= 1'b0;
            reduced_reg <= '0;
        end
        else
        begin
            if (load)
            begin
                if (count_reg < CW'(spf_pkg::MAX_TERMS))
                    count_reg <= count_reg + CW'(1);
                else
                    ovf_reg <= 1'b1;
            end
            if (cmd.clr_outer && !load)
            begin
                reduced_reg <= reduced_now;
                bad_reg <= reduced_now <= 41'sd0;
            end
            if (cmd.done)
            begin
                count_reg <= '0;
                ovf_reg <= 1'b0;
            end
        end
    end

    // threshold search: outer index j, inner sweep i
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg <= '0;
            i_reg <= '0;
            si_valid_reg <= 1'b0;
            s_reg <= '0;
            c_reg <= '0;
            ksum_reg <= '0;
            kcnt_reg <= '0;
            sj_reg <= '0;
        end
        else
        begin
            if (cmd.clr_outer)
            begin
                j_reg <= '0;
                ksum_reg <= '0;
                kcnt_reg <= '0;
            end
            if (cmd.clr_inner)
            begin
                i_reg <= '0;
                si_valid_reg <= 1'b0;
                s_reg <= '0;
                c_reg <= '0;
            end
            if (cmd.acc_inner)
            begin
                // first cycle latches s_j; later cycles accumulate each s_i not below s_j
                if (!si_valid_reg)
                    sj_reg <= rd_reg;
                else if (rd_reg >= sj_reg)
                begin
                    s_reg <= s_reg + 41'(rd_reg);
                    c_reg <= c_reg + CW'(1);
                end
                si_valid_reg <= 1'b1;
                if (i_reg != last_idx)
                    i_reg <= i_reg + IW'(1);
            end
            if (cmd.judge)
            begin
                if (s_reg - 41'(signed'({1'b0, c_reg})) * 41'(sj_reg) < reduced_reg)
                begin
                    ksum_reg <= ksum_reg + 41'(sj_reg);
                    kcnt_reg <= kcnt_reg + CW'(1);
                end
                j_reg <= j_reg + IW'(1);
            end
        end
    end

    // i_last: the element read this cycle is the final one, so the next
    // accumulation closes the sweep
    logic pend_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 1'b0;
        else if (cmd.clr_inner)
            pend_reg <= 1'b0;
        else if (cmd.acc_inner)
            pend_reg <= (i_reg == last_idx);
    end

    // divider inputs: numerator kept_sum - R with this judge folded in
    logic signed [40:0] judge_sum;
    logic               judge_keep;
    assign judge_keep = (s_reg - 41'(signed'({1'b0, c_reg})) * 41'(sj_reg)) < reduced_reg;
    assign judge_sum = judge_keep ? ksum_reg + 41'(sj_reg) : ksum_reg;

    logic signed [41:0] num;
    assign num = 42'(judge_sum) - 42'(reduced_reg);

    // restoring divider, one quotient bit per cycle, on |num|
    logic [41:0] rem_sh;
    assign rem_sh = {rem_reg[40:0], quo_reg[41]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            quo_reg <= '0;
            neg_reg <= 1'b0;
            dstep_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            neg_reg <= num[41];
            quo_reg <= num[41] ? 42'(-num) : 42'(num);
            rem_reg <= '0;
            dstep_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dstep_reg <= dstep_reg + 6'd1;
            if (rem_sh >= 42'(kcnt_reg))
            begin
                rem_reg <= rem_sh - 42'(kcnt_reg);
                quo_reg <= {quo_reg[40:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[40:0], 1'b0};
            end
        end
    end

    // floor rounding and saturation of theta
    logic signed [43:0] q_signed;
    always_comb
    begin
        if (neg_reg)
            q_signed = -44'(quo_reg) - ((rem_reg != '0) ? 44'sd1 : 44'sd0);
        else
            q_signed = 44'(quo_reg);
    end

    logic signed [31:0] theta_sat;
    assign theta_sat = (q_signed > 44'sd2147483647) ? 32'sh7FFF_FFFF :
                       (q_signed < -44'sd2147483648) ? 32'sh8000_0000 : q_signed[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            theta_reg <= '0;
        else if (cmd.clr_outer)
            theta_reg <= '0;
        else if (cmd.div_step && dstep_reg == 6'd42)
            theta_reg <= theta_sat;
    end

    // emit
    logic signed [33:0] diff;
    logic signed [33:0] res;
    logic signed [31:0] res_sat;
    assign diff = 34'(rd_reg) - 34'(theta_reg);
    assign res = ((diff < 0) ? 34'sd0 : diff) + 34'(signed'({1'b0, floor_reg}));
    assign res_sat = (res > 34'sd2147483647) ? 32'sh7FFF_FFFF : res[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_reg <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit;
            if (cmd.clr_emit)
                e_reg <= '0;
            else if (cmd.emit)
                e_reg <= e_reg + IW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg.value_out <= bad_reg ? 32'(signed'({1'b0, floor_reg})) : res_sat;
            out_reg.index_out <= e_reg;
            out_reg.last_out  <= (e_reg == last_idx);
            out_reg.truncated <= ovf_reg;
            out_reg.bad_total <= bad_reg;
        end
    end

    assign status.bad      = (reduced_now <= 41'sd0);
    assign status.j_last   = (j_reg == last_idx);
    assign status.i_last   = pend_reg;
    assign status.div_last = (dstep_reg == 6'd42);
    assign status.e_last   = (e_reg == last_idx);

    assign strobe   = strobe_reg;
    assign out_beat = out_reg;

endmodule

// ----- src/spf_checker.sv -----
// Port-level checker for the simplex projection block, bound to the top.
// Depends on spf_pkg.
module spf_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               busy,
    input logic               strobe,
    input spf_pkg::out_beat_t out_beat
);

    // results appear only while busy, apart from the last beat
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy || out_beat.last_out)
        else $error("result beat outside a run");

    // last beat frees the block
    a_last_free: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && out_beat.last_out |-> !busy)
        else $error("block still busy after last beat");

    // result beats never come back to back
    a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe)
        else $error("back-to-back result beats");

    // bad total forces the floor output to be non-negative
    a_bad_floor: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && out_beat.bad_total |-> !out_beat.value_out[31])
        else $error("bad total beat with negative value");

endmodule

bind simplex_projection_with_floor spf_checker u_spf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .busy     (busy),
    .strobe   (strobe),
    .out_beat (out_beat)
);
